FILE: hw/rtl/itb_pkg.sv
// shared constants and the digit-to-ascii helper for the integer-to-text converter
// no dependencies; imported by integer_to_text_in_base_top
package itb_pkg;

	// fixed field widths
	localparam int IN_WIDTH    = 64;
	localparam int RADIX_W     = 6;
	localparam int CHAR_W      = 8;
	localparam int DIGIT_W     = 6;

	// design sizing
	localparam int VALUE_WIDTH = 64;
	localparam int MAX_DIGITS  = 64;

	// divider: quotient bits resolved per cycle
	localparam int BITS_PER_CYC = 8;
	localparam int DIV_CYCLES   = (VALUE_WIDTH + BITS_PER_CYC - 1) / BITS_PER_CYC;
	localparam int DIV_W        = DIV_CYCLES * BITS_PER_CYC;
	localparam int CYC_W        = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;
	localparam int IDX_W        = $clog2(MAX_DIGITS);
	localparam int CNT_W        = $clog2(MAX_DIGITS + 1);

	// radix limits
	localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd2;
	localparam logic [RADIX_W-1:0] RADIX_MAX = 6'd36;
	localparam logic [RADIX_W-1:0] RADIX_DEC = 6'd10;

	// ascii codes
	localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CH_A     = 8'h61;
	localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
	localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
	localparam logic [CHAR_W-1:0] CH_Z     = 8'h7A;

	localparam logic [DIGIT_W-1:0] DIGIT_NINE = 6'd9;
	localparam logic [DIGIT_W-1:0] DIGIT_TEN  = 6'd10;

	function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
		logic [CHAR_W-1:0] c;
		if (d > DIGIT_NINE) begin
			c = CH_A + CHAR_W'(d - DIGIT_TEN);
		end else begin
			c = CH_ZERO + CHAR_W'(d);
		end
		return c;
	endfunction

endpackage

FILE: hw/rtl/integer_to_text_in_base_top.sv
// integer-to-text converter: signed integer plus radix in, ascii characters out
// depends on itb_pkg (sizes, ascii codes, digit_char)

// Converts one two's-complement integer (low VALUE_WIDTH bits of value) to
// ascii text in radix 2..36 and sends it one character per output beat, most
// significant character first, with last high on the final character. Digits
// above nine are lowercase letters; zero gives the single character '0'.
// Radix below 2 acts as 2 and above 36 acts as 36. Only radix 10 prints a
// leading '-' for negative values (the magnitude is exact even for the most
// negative value); every other radix prints the raw unsigned bit pattern.
// No terminator is sent. The block takes one number at a time: in_ready is
// high only while idle, i.e. after the last character beat has been taken.
// Sequence: the number is accepted, then one shared restoring divider retires
// BITS_PER_CYC (8) quotient bits per cycle until the quotient reaches zero.
// Each digit character then passes through digit store read, character load
// and beat, and is held on any output stall; a sign beat is loaded straight
// from the divider, goes out before the digits and also waits for out_ready.
// Digits are kept in a 64 x 6 store written once per digit and read once per
// digit character; it needs no clearing after reset.
module integer_to_text_in_base_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic signed [itb_pkg::IN_WIDTH-1:0] value,
	input  logic        [itb_pkg::RADIX_W-1:0]  radix,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic        [itb_pkg::CHAR_W-1:0]   character,
	output logic                                last
);
	import itb_pkg::*;

	// sequencer, one-hot
	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_DIV  = 5'b00010,
		ST_RD   = 5'b00100,
		ST_LOAD = 5'b01000,
		ST_WAIT = 5'b10000
	} state_t;

	state_t state_q;

	// control registers
	logic [CYC_W-1:0]   cyc_q;      // divider cycle within current digit
	logic [CNT_W-1:0]   cnt_q;      // digits stored so far
	logic [IDX_W-1:0]   idx_q;      // digit being sent
	logic               sign_q;     // '-' still to send
	logic               valid_q;

	// datapath registers
	logic [DIV_W-1:0]   div_q;      // dividend shifting out, quotient shifting in
	logic [DIGIT_W-1:0] rem_q;      // partial remainder
	logic [RADIX_W-1:0] radix_q;
	logic [DIGIT_W-1:0] rd_q;       // registered store read
	logic [CHAR_W-1:0]  char_q;
	logic               last_q;

	// digit store, least significant digit at entry zero
	logic [DIGIT_W-1:0] digit_mem [MAX_DIGITS];

	// input decode
	logic [VALUE_WIDTH-1:0] pattern;
	logic [VALUE_WIDTH-1:0] magnitude;
	logic [RADIX_W-1:0]     radix_c;
	logic                   neg_dec;
	logic                   in_fire;

	// divider step results
	logic [DIV_W-1:0]   div_n;
	logic [DIGIT_W-1:0] rem_n;
	logic               cyc_last;
	logic               quo_zero;
	logic               store_full;
	logic [CNT_W-1:0]   cnt_n;
	logic [CNT_W-1:0]   top_idx;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign out_valid = valid_q;
	assign character = char_q;
	assign last      = last_q;

	always_comb begin
		pattern = value[VALUE_WIDTH-1:0];
		if (radix < RADIX_MIN) begin
			radix_c = RADIX_MIN;
		end else if (radix > RADIX_MAX) begin
			radix_c = RADIX_MAX;
		end else begin
			radix_c = radix;
		end
		neg_dec   = pattern[VALUE_WIDTH-1] && (radix_c == RADIX_DEC);
		magnitude = neg_dec ? (~pattern + VALUE_WIDTH'(1)) : pattern;
	end

	// shared divider: BITS_PER_CYC restoring steps on a narrow remainder
	always_comb begin
		logic [DIGIT_W:0]   r;
		logic [DIV_W-1:0]   d;
		r = {1'b0, rem_q};
		d = div_q;
		for (int i = 0; i < BITS_PER_CYC; i++) begin
			r = {r[DIGIT_W-1:0], d[DIV_W-1]};
			d = {d[DIV_W-2:0], 1'b0};
			if (r >= {1'b0, radix_q}) begin
				r    = r - {1'b0, radix_q};
				d[0] = 1'b1;
			end
		end
		div_n = d;
		rem_n = r[DIGIT_W-1:0];
	end

	assign cyc_last   = (cyc_q == CYC_W'(DIV_CYCLES - 1));
	assign quo_zero   = (div_n == '0);
	assign store_full = (cnt_q >= CNT_W'(MAX_DIGITS));
	assign cnt_n      = store_full ? cnt_q : (cnt_q + CNT_W'(1));
	assign top_idx    = cnt_n - CNT_W'(1);

	// sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cyc_q   <= '0;
			cnt_q   <= '0;
			idx_q   <= '0;
			sign_q  <= 1'b0;
			valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						sign_q  <= neg_dec;
						cyc_q   <= '0;
						cnt_q   <= '0;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (cyc_last) begin
						cyc_q <= '0;
						cnt_q <= cnt_n;
						idx_q <= top_idx[IDX_W-1:0];
						if (quo_zero) begin
							if (sign_q) begin
								valid_q <= 1'b1;
								state_q <= ST_WAIT;
							end else begin
								state_q <= ST_RD;
							end
						end
					end else begin
						cyc_q <= cyc_q + CYC_W'(1);
					end
				end
				ST_RD: begin
					state_q <= ST_LOAD;
				end
				ST_LOAD: begin
					valid_q <= 1'b1;
					state_q <= ST_WAIT;
				end
				ST_WAIT: begin
					if (out_ready) begin
						valid_q <= 1'b0;
						if (sign_q) begin
							sign_q  <= 1'b0;
							state_q <= ST_RD;
						end else if (idx_q == '0) begin
							state_q <= ST_IDLE;
						end else begin
							idx_q   <= idx_q - IDX_W'(1);
							state_q <= ST_RD;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
					valid_q <= 1'b0;
				end
			endcase
		end
	end

	// datapath, no reset needed
	always_ff @(posedge clk) begin
		if (in_fire) begin
			div_q   <= DIV_W'(magnitude);
			rem_q   <= '0;
			radix_q <= radix_c;
		end else if (state_q == ST_DIV) begin
			div_q <= div_n;
			rem_q <= cyc_last ? '0 : rem_n;
		end

		// keep only the least significant digits if the store overflows
		if ((state_q == ST_DIV) && cyc_last && !store_full) begin
			digit_mem[cnt_q[IDX_W-1:0]] <= rem_n;
		end

		if (state_q == ST_RD) begin
			rd_q <= digit_mem[idx_q];
		end

		if ((state_q == ST_DIV) && cyc_last && sign_q) begin
			char_q <= CH_MINUS;
			last_q <= 1'b0;
		end else if (state_q == ST_LOAD) begin
			char_q <= digit_char(rd_q);
			last_q <= (idx_q == '0);
		end
	end

	// input and output sides never active together
	assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("in_ready while a character beat is pending");

	// final character taken returns the block to idle
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && last) |=> in_ready)
		else $error("not idle after final character beat");

	// an accepted number always occupies the block
	assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> !in_ready)
		else $error("ready right after accepting a number");

	// only digits, lowercase letters or a sign ever go out
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((character == CH_MINUS && !last)
			|| (character >= CH_ZERO && character <= CH_NINE)
			|| (character >= CH_A && character <= CH_Z)))
		else $error("illegal character on output");

endmodule
